// ----- rtl/core/ffa_pkg.sv -----
`default_nettype none
package ffa_pkg;

  // Default sizing of the pool and segment headers
  localparam int DEF_POOL_BYTES   = 65536;
  localparam int DEF_HEADER_BYTES = 8;

  // Fixed field widths
  localparam int POOL_FIELD_W = 17;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;
  // Rounded request plus header always fits here (header at most 16 bytes)
  localparam int TOT_W        = 17;

  // Generic RAM defaults
  localparam int DEF_RAM_WIDTH = 15;
  localparam int DEF_RAM_DEPTH = 8192;

  // Register indexes
  localparam logic REG_POOL = 1'b0;
  localparam logic REG_BASE = 1'b1;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NULL    = 2'd1,
    ST_FREED   = 2'd2,
    ST_FOREIGN = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_WALK,
    S_SPLIT,
    S_FOL,
    S_DONE
  } state_t;

  typedef struct packed {
    cmd_t        command;
    logic [15:0] request_bytes;
    logic [31:0] address;
  } in_req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] payload_address;
  } out_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/core/first_fit_heap_allocator.sv -----
// The walk visits segment headers in address order, with one read of the header memory
// per segment, and the result is registered; running off the end of the pool, a split
// (S_SPLIT) or a successful free (S_FOL) each add a step; zero-size and null go to S_DONE.
// Throughput: one request at a time; the next one is taken once the result is queued.
// Reset (synchronous, rst_n low): pool is 65536 bytes (clamped to capacity), base 0;
// after reset, state S_INIT writes the single free header and stalls input.
`default_nettype none
module first_fit_heap_allocator #(
  parameter int POOL_BYTES   = ffa_pkg::DEF_POOL_BYTES,
  parameter int HEADER_BYTES = ffa_pkg::DEF_HEADER_BYTES
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire ffa_pkg::in_req_t           in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output ffa_pkg::out_rsp_t               out_data,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [ffa_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [ffa_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [ffa_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import ffa_pkg::*;

  localparam int GRAN_LG = (HEADER_BYTES % 8 == 0) ? 3 :
                           (HEADER_BYTES % 4 == 0) ? 2 :
                           (HEADER_BYTES % 2 == 0) ? 1 : 0;
  localparam int DEPTH   = POOL_BYTES >> GRAN_LG;
  localparam int GW      = $clog2(DEPTH + 1);
  localparam int AW      = $clog2(DEPTH);

  logic [GW-1:0] pool_gran;
  logic [31:0]   base_address;
  logic          wr_pool;
  logic [GW-1:0] new_gran;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [GW:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [GW:0]   mem_rdata;

  ffa_cfg #(
    .POOL_BYTES   (POOL_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .pool_gran    (pool_gran),
    .base_address (base_address),
    .wr_pool      (wr_pool),
    .new_gran     (new_gran)
  );

  // Segment headers, one entry per granule: {used, size in granules}
  ffa_ram #(
    .WIDTH (GW + 1),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ffa_ctrl #(
    .POOL_BYTES   (POOL_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .pool_gran    (pool_gran),
    .base_address (base_address),
    .wr_pool      (wr_pool),
    .new_gran     (new_gran),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

endmodule
`default_nettype wire

// ----- rtl/core/ffa_ram.sv -----
`default_nettype none
module ffa_ram #(
  parameter int WIDTH = ffa_pkg::DEF_RAM_WIDTH,
  parameter int DEPTH = ffa_pkg::DEF_RAM_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/ffa_cfg.sv -----
`default_nettype none
module ffa_cfg #(
  parameter int POOL_BYTES   = ffa_pkg::DEF_POOL_BYTES,
  parameter int HEADER_BYTES = ffa_pkg::DEF_HEADER_BYTES,
  localparam int GRAN_LG = (HEADER_BYTES % 8 == 0) ? 3 :
                           (HEADER_BYTES % 4 == 0) ? 2 :
                           (HEADER_BYTES % 2 == 0) ? 1 : 0,
  localparam int DEPTH   = POOL_BYTES >> GRAN_LG,
  localparam int GW      = $clog2(DEPTH + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [ffa_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire logic [ffa_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic      [ffa_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                             cfg_pready,
  output logic      [GW-1:0]               pool_gran,
  output logic      [31:0]                 base_address,
  output logic                             wr_pool,
  output logic      [GW-1:0]               new_gran
);
  import ffa_pkg::*;

  localparam int PW        = $clog2(POOL_BYTES + 1);
  localparam int MIN_POOL  = (HEADER_BYTES + 8 + 7) & ~7;
  localparam int RST_CLAMP = (65536 > POOL_BYTES) ? POOL_BYTES : 65536;
  localparam int RST_ALIGN = RST_CLAMP & ~7;
  localparam int RST_POOL  = (RST_ALIGN < MIN_POOL) ? MIN_POOL : RST_ALIGN;

  logic [PW-1:0] pool_bytes_r, pool_bytes_nxt;
  logic [31:0]   base_r, base_nxt;
  logic          wr_en;
  logic [31:0]   clamp;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Clamp to the pool capacity, align down to 8, raise to the smallest pool
  always_comb begin
    clamp = {{(32 - POOL_FIELD_W){1'b0}}, cfg_pwdata[POOL_FIELD_W-1:0]};
    if (clamp > 32'(POOL_BYTES)) begin
      clamp = 32'(POOL_BYTES);
    end
    clamp = clamp & ~32'd7;
    if (clamp < 32'(MIN_POOL)) begin
      clamp = 32'(MIN_POOL);
    end
  end

  always_comb begin
    pool_bytes_nxt = pool_bytes_r;
    base_nxt       = base_r;
    wr_pool        = 1'b0;
    if (wr_en) begin
      if (cfg_paddr[2] == REG_POOL) begin
        pool_bytes_nxt = clamp[PW-1:0];
        wr_pool        = 1'b1;
      end else begin
        base_nxt = cfg_pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_bytes_r <= PW'(RST_POOL);
      base_r       <= '0;
    end else begin
      pool_bytes_r <= pool_bytes_nxt;
      base_r       <= base_nxt;
    end
  end

  // Register readback
  always_comb begin
    if (cfg_paddr[2] == REG_BASE) begin
      cfg_prdata = base_r;
    end else begin
      cfg_prdata = 32'(pool_bytes_r);
    end
  end

  assign pool_gran    = GW'(pool_bytes_r >> GRAN_LG);
  assign new_gran     = GW'(clamp >> GRAN_LG);
  assign base_address = base_r;

endmodule
`default_nettype wire

// ----- rtl/core/ffa_ctrl.sv -----
`default_nettype none
module ffa_ctrl #(
  parameter int POOL_BYTES   = ffa_pkg::DEF_POOL_BYTES,
  parameter int HEADER_BYTES = ffa_pkg::DEF_HEADER_BYTES,
  localparam int GRAN_LG = (HEADER_BYTES % 8 == 0) ? 3 :
                           (HEADER_BYTES % 4 == 0) ? 2 :
                           (HEADER_BYTES % 2 == 0) ? 1 : 0,
  localparam int DEPTH   = POOL_BYTES >> GRAN_LG,
  localparam int GW      = $clog2(DEPTH + 1),
  localparam int AW      = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ffa_pkg::in_req_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ffa_pkg::out_rsp_t      out_data,
  input  wire logic [GW-1:0]     pool_gran,
  input  wire logic [31:0]       base_address,
  input  wire logic              wr_pool,
  input  wire logic [GW-1:0]     new_gran,
  output logic                   mem_we,
  output logic      [AW-1:0]     mem_waddr,
  output logic      [GW:0]       mem_wdata,
  output logic      [AW-1:0]     mem_raddr,
  input  wire logic [GW:0]       mem_rdata
);
  import ffa_pkg::*;

  localparam int MIN_SEG_G = (HEADER_BYTES + 8) >> GRAN_LG;
  localparam int CW        = ((GW > TOT_W) ? GW : TOT_W) + 1;

  state_t       state_r, state_nxt;
  cmd_t         cmd_r, cmd_nxt;
  logic [31:0]  addr_r, addr_nxt;
  logic [TOT_W-1:0] tot_r, tot_nxt;
  logic [GW-1:0] g_r, g_nxt;
  logic [GW-1:0] seg_size_r, seg_size_nxt;
  logic          prev_valid_r, prev_valid_nxt;
  logic [GW-1:0] prev_g_r, prev_g_nxt;
  logic [GW-1:0] prev_size_r, prev_size_nxt;
  logic          prev_used_r, prev_used_nxt;
  status_t       res_status_r, res_status_nxt;
  logic [31:0]   res_addr_r, res_addr_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_rsp_t      out_data_r, out_data_nxt;

  logic          cur_used;
  logic [GW-1:0] cur_size;
  logic [GW-1:0] walk_nxt;
  logic [GW-1:0] fol_g;
  logic [GW-1:0] merged;
  logic [31:0]   cur_payload;
  logic [TOT_W-1:0] req_total;
  logic          fits;
  logic          split;

  // Header fields of the segment currently read
  assign cur_used    = mem_rdata[GW];
  assign cur_size    = mem_rdata[GW-1:0];
  assign walk_nxt    = g_r + cur_size;
  assign fol_g       = g_r + seg_size_r;
  assign cur_payload = base_address + (32'(g_r) << GRAN_LG) + 32'(HEADER_BYTES);

  // Request rounded up to 8 plus header, in bytes
  assign req_total = ((TOT_W'(in_data.request_bytes) + TOT_W'(7)) & ~TOT_W'(7))
                     + TOT_W'(HEADER_BYTES);

  assign fits  = !cur_used && (CW'(cur_size) >= CW'(tot_r));
  assign split = (CW'(cur_size) - CW'(tot_r)) > CW'(MIN_SEG_G);

  // Next state and datapath
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    addr_nxt       = addr_r;
    tot_nxt        = tot_r;
    g_nxt          = g_r;
    seg_size_nxt   = seg_size_r;
    prev_valid_nxt = prev_valid_r;
    prev_g_nxt     = prev_g_r;
    prev_size_nxt  = prev_size_r;
    prev_used_nxt  = prev_used_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = g_r[AW-1:0];
    mem_wdata      = '0;
    merged         = seg_size_r;

    // Walk reads the next header straight from the current size
    mem_raddr = (state_r == S_WALK) ? walk_nxt[AW-1:0] : '0;
    in_stall  = (state_r != S_IDLE);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = {1'b0, pool_gran};
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = in_data.command;
          addr_nxt       = in_data.address;
          tot_nxt        = TOT_W'(req_total >> GRAN_LG);
          g_nxt          = '0;
          prev_valid_nxt = 1'b0;
          res_addr_nxt   = '0;
          res_status_nxt = ST_OK;
          if (in_data.command == CMD_ALLOC && in_data.request_bytes == '0) begin
            res_status_nxt = ST_NULL;
            state_nxt      = S_DONE;
          end else if (in_data.command == CMD_FREE && in_data.address == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (g_r >= pool_gran) begin
          // End of pool reached without a hit
          res_status_nxt = (cmd_r == CMD_ALLOC) ? ST_NULL : ST_FOREIGN;
          state_nxt      = S_DONE;
        end else if (cmd_r == CMD_ALLOC && fits) begin
          mem_we         = 1'b1;
          mem_wdata      = {1'b1, split ? GW'(tot_r) : cur_size};
          res_status_nxt = ST_OK;
          res_addr_nxt   = cur_payload;
          if (split) begin
            g_nxt        = g_r + GW'(tot_r);
            seg_size_nxt = cur_size - GW'(tot_r);
            state_nxt    = S_SPLIT;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (cmd_r == CMD_FREE && cur_payload == addr_r) begin
          if (!cur_used) begin
            res_status_nxt = ST_FREED;
            state_nxt      = S_DONE;
          end else begin
            // Follower header is being read this cycle
            seg_size_nxt = cur_size;
            state_nxt    = S_FOL;
          end
        end else begin
          prev_valid_nxt = 1'b1;
          prev_g_nxt     = g_r;
          prev_size_nxt  = cur_size;
          prev_used_nxt  = cur_used;
          g_nxt          = walk_nxt;
        end
      end

      S_SPLIT: begin
        // Header of the free remainder
        mem_we    = 1'b1;
        mem_wdata = {1'b0, seg_size_r};
        state_nxt = S_DONE;
      end

      S_FOL: begin
        // Merge with a free follower, then with a free predecessor
        if (fol_g < pool_gran && !cur_used) begin
          merged = seg_size_r + cur_size;
        end
        mem_we = 1'b1;
        if (prev_valid_r && !prev_used_r) begin
          mem_waddr = prev_g_r[AW-1:0];
          mem_wdata = {1'b0, prev_size_r + merged};
        end else begin
          mem_wdata = {1'b0, merged};
        end
        res_status_nxt = ST_OK;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: res_status_r, payload_address: res_addr_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Pool size write starts over with one free segment
    if (wr_pool) begin
      mem_we    = 1'b1;
      mem_waddr = '0;
      mem_wdata = {1'b0, new_gran};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    addr_r       <= addr_nxt;
    tot_r        <= tot_nxt;
    g_r          <= g_nxt;
    seg_size_r   <= seg_size_nxt;
    prev_valid_r <= prev_valid_nxt;
    prev_g_r     <= prev_g_nxt;
    prev_size_r  <= prev_size_nxt;
    prev_used_r  <= prev_used_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ----- rtl/core/ffa_checker.sv -----
`default_nettype none
module ffa_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire ffa_pkg::out_rsp_t          out_data
);
  import ffa_pkg::*;

  // A held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Only a successful allocation carries an address
  a_null_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.payload_address == '0)
    else $error("failed request returned an address");

  // One request in flight: input stalls right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken during processing");

  // A new result only rises after input was stalled
  a_result_order: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request in flight");

endmodule

bind first_fit_heap_allocator ffa_checker u_ffa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// ----- tb/first_fit_heap_allocator_tb.sv -----
`timescale 1ns / 100ps
module first_fit_heap_allocator_tb;
  import ffa_pkg::*;

  localparam int HDR_BYTES   = DEF_HEADER_BYTES;
  localparam int POOL_CAP    = DEF_POOL_BYTES;
  localparam int MIN_SEG     = HDR_BYTES + 8;
  localparam int MIN_POOL    = ((MIN_SEG + 7) / 8) * 8;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 116;
  localparam logic [CFG_AW-1:0] ADDR_POOL = {REG_POOL, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_BASE = {REG_BASE, 2'b00};

  typedef struct {
    in_req_t  req;
    bit       pinned;
    out_rsp_t rsp;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_req_t           in_data;
  logic              out_valid;
  logic              out_stall;
  out_rsp_t          out_data;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // Directed rows may carry a typed-in response, travelling alongside in_data
  logic              req_pinned;
  out_rsp_t          req_pin_rsp;

  // Shadow copy of the segment list and registers
  int unsigned       seg_off[$];
  int unsigned       seg_size[$];
  bit                seg_used[$];
  int unsigned       pool_q;
  logic [31:0]       base_q;

  out_rsp_t          pending_responses[$];
  logic [31:0]       live_addrs[$];
  int                items_sent;
  int                results_seen;
  int                fail_count;
  int                send_idle_pct;
  int                stall_pct;
  bit                hold_out;
  int                quiet_cycles;

  first_fit_heap_allocator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pool write: clamp, round down to 8, raise to the minimum, one free segment
  function automatic void reinit_pool(logic [16:0] v);
    int unsigned p;
    p = v;
    if (p > POOL_CAP) p = POOL_CAP;
    p = p - (p % 8);
    if (p < MIN_POOL) p = MIN_POOL;
    pool_q = p;
    seg_off.delete();
    seg_size.delete();
    seg_used.delete();
    seg_off.push_back(0);
    seg_size.push_back(p);
    seg_used.push_back(1'b0);
  endfunction

  function automatic logic [31:0] seg_payload(int i);
    return base_q + 32'(seg_off[i]) + 32'(HDR_BYTES);
  endfunction

  // Computes the response of one request and updates the shadow segment list
  function automatic out_rsp_t predict_heap_response(in_req_t r);
    out_rsp_t    rsp;
    int unsigned total;
    int          hit;
    hit = -1;
    rsp.status = ST_OK;
    rsp.payload_address = '0;
    if (r.command == CMD_ALLOC) begin
      rsp.status = ST_NULL;
      if (r.request_bytes != 0) begin
        total = ((int'(r.request_bytes) + 7) / 8) * 8 + HDR_BYTES;
        for (int i = 0; i < seg_off.size(); i++)
          if (hit < 0 && !seg_used[i] && seg_size[i] >= total) hit = i;
        if (hit >= 0) begin
          // split only when the remainder is larger than a header plus 8 bytes
          if (seg_size[hit] - total > MIN_SEG) begin
            seg_off.insert(hit + 1, seg_off[hit] + total);
            seg_size.insert(hit + 1, seg_size[hit] - total);
            seg_used.insert(hit + 1, 1'b0);
            seg_size[hit] = total;
          end
          seg_used[hit] = 1'b1;
          rsp.status = ST_OK;
          rsp.payload_address = seg_payload(hit);
        end
      end
    end else if (r.address != 0) begin
      // address lookup comes before the already-free check
      for (int i = 0; i < seg_off.size(); i++)
        if (hit < 0 && seg_payload(i) == r.address) hit = i;
      if (hit < 0) begin
        rsp.status = ST_FOREIGN;
      end else if (!seg_used[hit]) begin
        rsp.status = ST_FREED;
      end else begin
        seg_used[hit] = 1'b0;
        if (hit + 1 < seg_off.size() && !seg_used[hit + 1]) begin
          seg_size[hit] = seg_size[hit] + seg_size[hit + 1];
          seg_off.delete(hit + 1);
          seg_size.delete(hit + 1);
          seg_used.delete(hit + 1);
        end
        if (hit > 0 && !seg_used[hit - 1]) begin
          seg_size[hit - 1] = seg_size[hit - 1] + seg_size[hit];
          seg_off.delete(hit);
          seg_size.delete(hit);
          seg_used.delete(hit);
        end
      end
    end
    return rsp;
  endfunction

  function automatic dir_row_t mk_row(cmd_t c, logic [15:0] nbytes, logic [31:0] addr,
                                      bit pin, status_t st, logic [31:0] pa);
    dir_row_t row;
    row.req.command = c;
    row.req.request_bytes = nbytes;
    row.req.address = addr;
    row.pinned = pin;
    row.rsp.status = st;
    row.rsp.payload_address = pa;
    return row;
  endfunction

  // Predict on request acceptance, check on result acceptance
  always @(posedge clk) begin
    out_rsp_t want;
    out_rsp_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = predict_heap_response(in_data);
        if (req_pinned) want = req_pin_rsp;
        if (in_data.command == CMD_ALLOC && want.status == ST_OK)
          live_addrs.push_back(want.payload_address);
        pending_responses.push_back(want);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        got = out_data;
        if (pending_responses.size() == 0) begin
          $error("result with nothing expected: status %0d payload_address %h",
                 got.status, got.payload_address);
          fail_count++;
        end else begin
          want = pending_responses.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.payload_address !== want.payload_address) begin
            $error("payload_address: expected %h, got %h",
                   want.payload_address, got.payload_address);
            fail_count++;
          end
        end
      end
    end
  end

  // Result side back-pressure, with an optional long hold-off
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_req(input in_req_t r, input bit pin, input out_rsp_t pin_rsp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_data     <= r;
    req_pinned  <= pin;
    req_pin_rsp <= pin_rsp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_POOL) begin
      reinit_pool(data[16:0]);
      live_addrs.delete();
    end else begin
      base_q = data;
    end
  endtask

  initial begin
    dir_row_t    rows[$];
    in_req_t     r;
    out_rsp_t    no_pin;
    logic [31:0] phase_pool[6];
    logic [31:0] phase_base[6];
    int          send_mode[4];
    int          stall_mode[4];
    int          pick;
    int          idx;
    int          cap;

    phase_pool = '{32'h0001_0000, 32'h0001_FFFF, 32'd1000, 32'd0, 32'd2047, 32'd4100};
    phase_base = '{32'h0000_0000, 32'hFFFF_0000, 32'hFFFF_FFF8, 32'hFFFF_FFFF,
                   32'h0001_2340, 32'h8000_0000};
    send_mode  = '{0, 53, 0, 32};
    stall_mode = '{0, 0, 53, 32};
    no_pin = '{status: ST_OK, payload_address: '0};

    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    req_pinned  <= 1'b0;
    req_pin_rsp <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    base_q = '0;
    reinit_pool(17'h10000);
    items_sent = 0;
    results_seen = 0;
    fail_count = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_out = 1'b0;
    quiet_cycles = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset pool of 64 KiB at base 0
    rows.push_back(mk_row(CMD_ALLOC, 16'd0, 32'h0, 1, ST_NULL, 32'h0));
    rows.push_back(mk_row(CMD_FREE, 16'hFFFF, 32'h0, 1, ST_OK, 32'h0));
    rows.push_back(mk_row(CMD_FREE, 16'd0, 32'd8, 1, ST_FREED, 32'h0));
    rows.push_back(mk_row(CMD_FREE, 16'd0, 32'hFFFF_FFFF, 1, ST_FOREIGN, 32'h0));
    rows.push_back(mk_row(CMD_ALLOC, 16'hFFFF, 32'hFFFF_FFFF, 1, ST_NULL, 32'h0));
    rows.push_back(mk_row(CMD_ALLOC, 16'd1, 32'h0, 1, ST_OK, 32'd8));
    rows.push_back(mk_row(CMD_ALLOC, 16'd8, 32'h0, 1, ST_OK, 32'd24));
    rows.push_back(mk_row(CMD_FREE, 16'd0, 32'd8, 1, ST_OK, 32'h0));
    rows.push_back(mk_row(CMD_FREE, 16'd0, 32'd8, 1, ST_FREED, 32'h0));
    rows.push_back(mk_row(CMD_FREE, 16'd0, 32'd16, 1, ST_FOREIGN, 32'h0));
    // hole too small for a 24-byte segment, then exact refill of the hole
    rows.push_back(mk_row(CMD_ALLOC, 16'd9, 32'h0, 0, ST_OK, 32'h0));
    rows.push_back(mk_row(CMD_ALLOC, 16'd7, 32'h0, 0, ST_OK, 32'h0));
    // a free with no merge, then merges with both neighbours and with the follower
    rows.push_back(mk_row(CMD_FREE, 16'd0, 32'd24, 0, ST_OK, 32'h0));
    rows.push_back(mk_row(CMD_FREE, 16'd0, 32'd40, 0, ST_OK, 32'h0));
    rows.push_back(mk_row(CMD_FREE, 16'd0, 32'd8, 0, ST_OK, 32'h0));
    // remainder of exactly header+8: no split, so nothing else fits
    rows.push_back(mk_row(CMD_ALLOC, 16'd65512, 32'h0, 0, ST_OK, 32'h0));
    rows.push_back(mk_row(CMD_ALLOC, 16'd1, 32'h0, 0, ST_OK, 32'h0));
    rows.push_back(mk_row(CMD_FREE, 16'd0, 32'd8, 0, ST_OK, 32'h0));
    // remainder of 24: split, tail taken without a further split
    rows.push_back(mk_row(CMD_ALLOC, 16'd65504, 32'h0, 0, ST_OK, 32'h0));
    rows.push_back(mk_row(CMD_ALLOC, 16'd8, 32'h0, 0, ST_OK, 32'h0));
    rows.push_back(mk_row(CMD_FREE, 16'd0, 32'd65520, 0, ST_OK, 32'h0));
    rows.push_back(mk_row(CMD_FREE, 16'd0, 32'd8, 0, ST_OK, 32'h0));
    // whole pool in one segment
    rows.push_back(mk_row(CMD_ALLOC, 16'd65528, 32'h0, 0, ST_OK, 32'h0));
    rows.push_back(mk_row(CMD_FREE, 16'd0, 32'd8, 0, ST_OK, 32'h0));
    foreach (rows[i]) send_req(rows[i].req, rows[i].pinned, rows[i].rsp);

    // Random phases, each with its own pool and base, and one of four idling mixes
    for (int ph = 0; ph < 6; ph++) begin
      wait_all_results();
      cfg_write(ADDR_BASE, phase_base[ph]);
      cfg_write(ADDR_POOL, phase_pool[ph]);
      send_idle_pct = send_mode[ph % 4];
      stall_pct = stall_mode[ph % 4];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 40) hold_out = 1'b1;
        if (ph == 1 && n == 50) wait_all_results();
        r.request_bytes = 16'($urandom());
        r.address = $urandom();
        pick = $urandom_range(99);
        cap = (pool_q > 65535) ? 65535 : pool_q;
        if (pick < 45 || (pick < 80 && live_addrs.size() == 0)) begin
          r.command = CMD_ALLOC;
          idx = $urandom_range(99);
          if (idx < 70) r.request_bytes = 16'($urandom_range(64, 1));
          else if (idx < 90) r.request_bytes = 16'($urandom_range(512, 65));
          else if (idx < 97) r.request_bytes = 16'($urandom_range(cap, 1));
        end else if (pick < 80) begin
          r.command = CMD_FREE;
          idx = $urandom_range(live_addrs.size() - 1);
          r.address = live_addrs[idx];
          // keeping some addresses gives double frees and frees after reuse
          if ($urandom_range(99) < 85) live_addrs.delete(idx);
        end else if (pick < 87) begin
          r.command = CMD_FREE;
          r.address = base_q + 32'(8 * $urandom_range(pool_q / 8));
        end else if (pick < 93) begin
          r.command = CMD_FREE;
        end else if (pick < 96) begin
          r.command = CMD_FREE;
          r.address = '0;
        end else begin
          r.command = CMD_ALLOC;
          r.request_bytes = '0;
        end
        send_req(r, 1'b0, no_pin);
      end
    end

    wait_all_results();
    repeat (20) @(posedge clk);
    if (pending_responses.size() != 0) begin
      $error("%0d expected results never arrived", pending_responses.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
